>>> rtl/core/first_fit_pool_allocator_core_assert.svh
// Assertion macros shared by the allocator RTL.
// Needs a signal named clock and a signal named reset in the module that uses them.
`ifndef FIRST_FIT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define FFPA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFPA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ffpa_pkg.sv
// Types and constants of the first-fit pool allocator.
// No dependencies; used by the cell, the editor and the top level.
`default_nettype none
package ffpa_pkg;

   localparam int LEN_BITS = 16;
   localparam int QDEPTH = 4;
   localparam logic [LEN_BITS-1:0] POOL_RESET = 16'd4096;

   typedef struct packed {
      logic                used;
      logic [LEN_BITS-1:0] len;
   } entry_type;

   localparam entry_type ZERO_ENTRY = '{used: 1'b0, len: '0};

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_NOFIT    = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_ZERO     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,
      ST_DONE
   } state_type;

   // control from the sequencer to the stream editor
   typedef struct packed {
      logic start;
      logic active;
      logic in_rng;
      logic pop_en;
      logic last;
      logic is_free;
   } pass_ctrl_type;

   // outcome of one pass
   typedef struct packed {
      logic                found;
      logic                full;
      logic                split;
      logic [1:0]          merges;
      logic [LEN_BITS-1:0] grant;
   } edit_stat_type;

endpackage
`default_nettype wire

>>> rtl/core/ffpa_ifs.sv
// Handshake channels of the allocator: request and response.
// Depends on nothing; widths follow the fixed item fields.
`default_nettype none
interface ffpa_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] req_size;
   logic [15:0] req_offset;
   modport source (output valid, cmd, req_size, req_offset, input ready);
   modport sink (input valid, cmd, req_size, req_offset, output ready);
endinterface

interface ffpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] grant_offset;
   modport source (output valid, status, grant_offset, input ready);
   modport sink (input valid, status, grant_offset, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ffpa_cell.sv
// One section cell of the table chain: length and used flag.
// Depends on ffpa_pkg.
`default_nettype none
module ffpa_cell #(
   parameter bit HEAD = 1'b0
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          load,
   input  wire [ffpa_pkg::LEN_BITS-1:0] pool_size,
   input  wire                          shift_en,
   input  wire ffpa_pkg::entry_type     shift_in,
   output ffpa_pkg::entry_type          entry_out
);
   import ffpa_pkg::*;

   entry_type entry_ff;
   entry_type rst_val;
   entry_type ld_val;

   // head cell starts as the whole pool, the rest empty
   always_comb begin
      rst_val = ZERO_ENTRY;
      ld_val = ZERO_ENTRY;
      if (HEAD) begin
         rst_val.len = POOL_RESET;
         ld_val.len = pool_size;
      end
   end

   // hold, reload on a pool write, or take the neighbor's entry
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= rst_val;
      end else if (load) begin
         entry_ff <= ld_val;
      end else if (shift_en) begin
         entry_ff <= shift_in;
      end
   end

   assign entry_out = entry_ff;

endmodule
`default_nettype wire

>>> rtl/core/ffpa_editor.sv
// Stream editor at the head of the chain: offset tracking, first-fit split,
// free with merge, through a short queue. Depends on ffpa_pkg.
`default_nettype none
`include "first_fit_pool_allocator_core_assert.svh"
module ffpa_editor #(
   parameter int OFFSET_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire ffpa_pkg::pass_ctrl_type ctrl,
   input  wire [ffpa_pkg::LEN_BITS-1:0] alloc_size,
   input  wire [OFFSET_BITS-1:0]        target,
   input  wire                          table_full,
   input  wire ffpa_pkg::entry_type     head,
   output ffpa_pkg::entry_type          emit,
   output ffpa_pkg::edit_stat_type      stat
);
   import ffpa_pkg::*;

   entry_type               q_ff [QDEPTH];
   entry_type               q_in [QDEPTH];
   logic [2:0]              qn_ff, qn_in;
   logic [OFFSET_BITS-1:0]  off_ff, off_in;
   logic                    found_ff, found_in;
   logic                    full_ff, full_in;
   logic                    split_ff, split_in;
   logic                    absorb_ff, absorb_in;
   logic [1:0]              merges_ff, merges_in;
   logic [LEN_BITS-1:0]     grant_ff, grant_in;
   logic [OFFSET_BITS+LEN_BITS-1:0] len_ext;
   logic [OFFSET_BITS+LEN_BITS-1:0] off_ext;
   logic [1:0]              pidx;
   logic                    fit;
   logic                    hit;

   assign len_ext = {{OFFSET_BITS{1'b0}}, head.len};
   assign off_ext = {{LEN_BITS{1'b0}}, off_ff};
   assign fit = !found_ff && !head.used && (head.len >= alloc_size);
   assign hit = !found_ff && (off_ff == target);

   // process the head entry, then pop the oldest queued item
   always_comb begin
      q_in = q_ff;
      qn_in = qn_ff;
      off_in = off_ff;
      found_in = found_ff;
      full_in = full_ff;
      split_in = split_ff;
      absorb_in = absorb_ff;
      merges_in = merges_ff;
      grant_in = grant_ff;
      emit = ZERO_ENTRY;
      pidx = qn_ff[1:0] - 2'd1;
      if (ctrl.start) begin
         qn_in = '0;
         off_in = '0;
         found_in = 1'b0;
         full_in = 1'b0;
         split_in = 1'b0;
         absorb_in = 1'b0;
         merges_in = '0;
         grant_in = '0;
      end else if (ctrl.active) begin
         if (ctrl.in_rng) begin
            off_in = off_ff + len_ext[OFFSET_BITS-1:0];
            if (!ctrl.is_free) begin
               if (fit) begin
                  found_in = 1'b1;
                  grant_in = off_ext[LEN_BITS-1:0];
                  if (head.len == alloc_size) begin
                     q_in[qn_in[1:0]] = '{used: 1'b1, len: head.len};
                     qn_in = qn_in + 3'd1;
                  end else if (table_full) begin
                     full_in = 1'b1;
                     q_in[qn_in[1:0]] = head;
                     qn_in = qn_in + 3'd1;
                  end else begin
                     split_in = 1'b1;
                     q_in[qn_in[1:0]] = '{used: 1'b1, len: alloc_size};
                     qn_in = qn_in + 3'd1;
                     q_in[qn_in[1:0]] = '{used: 1'b0, len: head.len - alloc_size};
                     qn_in = qn_in + 3'd1;
                  end
               end else begin
                  q_in[qn_in[1:0]] = head;
                  qn_in = qn_in + 3'd1;
               end
            end else if (hit) begin
               // clear target, fold into a free predecessor
               found_in = 1'b1;
               absorb_in = 1'b1;
               if (qn_ff != 3'd0 && !q_ff[pidx].used) begin
                  q_in[pidx].len = q_ff[pidx].len + head.len;
                  merges_in = merges_ff + 2'd1;
               end else begin
                  q_in[qn_in[1:0]] = '{used: 1'b0, len: head.len};
                  qn_in = qn_in + 3'd1;
               end
            end else if (absorb_ff && !head.used) begin
               // fold a free successor into the cleared section
               absorb_in = 1'b0;
               q_in[pidx].len = q_ff[pidx].len + head.len;
               merges_in = merges_ff + 2'd1;
            end else begin
               absorb_in = 1'b0;
               q_in[qn_in[1:0]] = head;
               qn_in = qn_in + 3'd1;
            end
         end
         if (ctrl.pop_en && qn_in != 3'd0) begin
            emit = q_in[0];
            for (int k = 0; k < QDEPTH - 1; k++) begin
               q_in[k] = q_in[k+1];
            end
            qn_in = qn_in - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qn_ff <= '0;
         found_ff <= 1'b0;
         full_ff <= 1'b0;
         split_ff <= 1'b0;
         absorb_ff <= 1'b0;
         merges_ff <= '0;
      end else begin
         qn_ff <= qn_in;
         found_ff <= found_in;
         full_ff <= full_in;
         split_ff <= split_in;
         absorb_ff <= absorb_in;
         merges_ff <= merges_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      off_ff <= off_in;
      grant_ff <= grant_in;
   end

   assign stat = '{found: found_ff, full: full_ff, split: split_ff,
                   merges: merges_ff, grant: grant_ff};

   `FFPA_ASSERT_IMP(a_queue_depth, 1'b1, qn_ff <= 3'd3, "editor queue overrun")
   `FFPA_ASSERT_NXT(a_queue_drained, ctrl.active && ctrl.last, qn_ff == 3'd0,
                    "items left in queue after pass")
   `FFPA_ASSERT_IMP(a_split_alloc, split_ff || full_ff, merges_ff == 2'd0,
                    "split and merge in one pass")

endmodule
`default_nettype wire

>>> rtl/core/first_fit_pool_allocator_core.sv
// Top level of the first-fit pool allocator: sequencer, section chain, response.
// Depends on ffpa_pkg, ffpa_ifs, ffpa_cell, ffpa_editor.
//
//   port       dir   handshake    carries
//   req_chan   in    valid/ready  cmd, req_size, req_offset
//   rsp_chan   out   valid/ready  status, grant_offset
//   csr_wr_*   in    write enable pool_size
//
// An item goes through accept, rotation of the cell chain and response load;
// an allocate of size zero skips the rotation.
// Any other request rotates the whole chain once through the head editor.
// Reset and a pool_size write set one free section.
// One request in flight; a new one is taken while a response waits.
`default_nettype none
`include "first_fit_pool_allocator_core_assert.svh"
module first_fit_pool_allocator_core #(
   parameter int MAX_SECTIONS = 128,
   parameter int OFFSET_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   ffpa_req_if.sink                     req_chan,
   ffpa_rsp_if.source                   rsp_chan,
   input  wire                          csr_wr_en,
   input  wire [ffpa_pkg::LEN_BITS-1:0] csr_wr_data
);
   import ffpa_pkg::*;

   localparam int CW = $clog2(MAX_SECTIONS + 2);

   state_type               state_ff, state_in;
   logic [CW-1:0]           cyc_ff, cyc_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    cmd_ff, cmd_in;
   logic [LEN_BITS-1:0]     size_ff, size_in;
   logic [OFFSET_BITS-1:0]  target_ff, target_in;
   logic                    zero_ff, zero_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [LEN_BITS-1:0]     rsp_grant_ff, rsp_grant_in;
   logic [OFFSET_BITS+LEN_BITS-1:0] tgt_ext;
   logic                    accept;
   pass_ctrl_type           ctrl;
   edit_stat_type           stat;
   entry_type               emit;
   entry_type               cell_q [MAX_SECTIONS];

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign tgt_ext = {{OFFSET_BITS{1'b0}}, req_chan.req_offset};

   // sequence: accept, rotate chain, load response
   always_comb begin
      state_in = state_ff;
      cyc_in = cyc_ff;
      count_in = count_ff;
      cmd_in = cmd_ff;
      size_in = size_ff;
      target_in = target_ff;
      zero_in = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in = rsp_grant_ff;
      ctrl = '0;
      ctrl.is_free = (cmd_ff == CMD_FREE);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_chan.cmd;
               size_in = req_chan.req_size;
               target_in = tgt_ext[OFFSET_BITS-1:0];
               zero_in = (req_chan.cmd == CMD_ALLOC) && (req_chan.req_size == '0);
               cyc_in = '0;
               ctrl.start = 1'b1;
               state_in = zero_in ? ST_DONE : ST_PASS;
            end
         end
         ST_PASS: begin
            ctrl.active = 1'b1;
            ctrl.in_rng = (cyc_ff < count_ff);
            ctrl.pop_en = (cyc_ff >= CW'(2));
            ctrl.last = (cyc_ff == CW'(MAX_SECTIONS + 1));
            cyc_in = cyc_ff + CW'(1);
            if (ctrl.last) begin
               count_in = count_ff + CW'(stat.split) - CW'(stat.merges);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_grant_in = '0;
               if (zero_ff) begin
                  rsp_status_in = STAT_ZERO;
               end else if (cmd_ff == CMD_FREE) begin
                  rsp_status_in = stat.found ? STAT_OK : STAT_NOTFOUND;
               end else if (!stat.found) begin
                  rsp_status_in = STAT_NOFIT;
               end else if (stat.full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  rsp_status_in = STAT_OK;
                  rsp_grant_in = stat.grant;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_wr_en) begin
         count_in = CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cyc_ff <= '0;
         count_ff <= CW'(1);
         zero_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cyc_ff <= cyc_in;
         count_ff <= count_in;
         zero_ff <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      size_ff <= size_in;
      target_ff <= target_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff <= rsp_grant_in;
   end

   // section chain: each cell takes its upper neighbor, tail takes the editor
   for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
      entry_type nbr;
      if (k == MAX_SECTIONS - 1) begin : g_tail
         assign nbr = emit;
      end else begin : g_mid
         assign nbr = cell_q[k+1];
      end
      ffpa_cell #(.HEAD(k == 0)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (csr_wr_en),
         .pool_size (csr_wr_data),
         .shift_en  (ctrl.active),
         .shift_in  (nbr),
         .entry_out (cell_q[k])
      );
   end

   ffpa_editor #(.OFFSET_BITS(OFFSET_BITS)) u_editor (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .alloc_size (size_ff),
      .target     (target_ff),
      .table_full (count_ff == CW'(MAX_SECTIONS)),
      .head       (cell_q[0]),
      .emit       (emit),
      .stat       (stat)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.grant_offset = rsp_grant_ff;

   `FFPA_ASSERT_IMP(a_count_range, 1'b1,
                    count_ff >= CW'(1) && count_ff <= CW'(MAX_SECTIONS),
                    "section count out of range")
   `FFPA_ASSERT_NXT(a_busy_after_accept, accept, !req_chan.ready,
                    "request taken during a pass")
   `FFPA_ASSERT_NXT(a_pass_advance, state_ff == ST_PASS && !ctrl.last,
                    state_ff == ST_PASS && cyc_ff == $past(cyc_ff) + CW'(1),
                    "pass counter skipped")

endmodule
`default_nettype wire
